>>> rtl/isfd_pkg.sv
// shared constants, types and helpers of the imu serial frame decoder
package isfd_pkg;

	localparam int BUF_DEPTH  = 32;
	localparam int ADDR_W     = $clog2(BUF_DEPTH);
	// byte offsets during decode run up to 24, beyond the buffer when it is small
	localparam int OFF_W      = (ADDR_W + 1 > 5) ? ADDR_W + 1 : 5;
	// length byte plus overhead fits in nine bits
	localparam int TGT_W      = 9;
	localparam int QTY_W      = 4;
	localparam int N_QTY      = 10;
	localparam int VAL_W      = 16;

	localparam logic [7:0] HDR_BYTE = 8'h5a;
	localparam logic [7:0] MASK_ACC = 8'h01;
	localparam logic [7:0] MASK_GYR = 8'h02;
	localparam logic [7:0] MASK_ANG = 8'h10;
	localparam logic [7:0] MASK_TMP = 8'h40;

	localparam logic [TGT_W-1:0] LEN_EXTRA = 9'd5;
	localparam logic [OFF_W-1:0] FIRST_OFF = OFF_W'(4);
	localparam logic [QTY_W-1:0] QTY_TEMP  = 4'd9;

	// floor(x / 100) for 16-bit x as (x * 83887) >> 23
	localparam logic [16:0] TEMP_RECIP = 17'd83887;
	localparam int          TEMP_SHIFT = 23;
	localparam int          PROD_W     = 33;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_RDLO = 6'b000100,
		ST_WORD = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	typedef struct packed {
		logic wr;
		logic start;
		logic skip;
		logic rd_hi;
		logic rd_lo;
		logic cap_word;
		logic mul;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic frame_done;
		logic cur_present;
		logic scan_end;
		logic out_free;
	} sts_t;

	// one bit per quantity, set where the content mask selects its group
	function automatic logic [N_QTY-1:0] present_vec(input logic [7:0] mask);
		logic [N_QTY-1:0] p;
		p[2:0] = {3{|(mask & MASK_ACC)}};
		p[5:3] = {3{|(mask & MASK_GYR)}};
		p[8:6] = {3{|(mask & MASK_ANG)}};
		p[9]   = |(mask & MASK_TMP);
		return p;
	endfunction

endpackage

>>> rtl/isfd_if.sv
// valid/ready channel interfaces for received bytes and decoded results
interface isfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface isfd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [isfd_pkg::QTY_W-1:0]           quantity;
	logic signed [isfd_pkg::VAL_W-1:0]    value;
	logic                                 last;

	modport source (output valid, output quantity, output value, output last, input ready);
	modport sink (input valid, input quantity, input value, input last, output ready);
endinterface

>>> rtl/isfd_ram.sv
// generic single-write, single-read ram with registered read data
module isfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/isfd_ctrl.sv
// decode sequencer: byte intake, quantity scan, word fetch and result issue
module isfd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  isfd_pkg::sts_t sts,
	output isfd_pkg::cmd_t cmd
);

	isfd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			isfd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.wr   = in_valid;
				if (in_valid && sts.frame_done) begin
					cmd.start = 1'b1;
					state_d   = isfd_pkg::ST_SCAN;
				end
			end
			isfd_pkg::ST_SCAN: begin
				if (sts.scan_end) begin
					state_d = isfd_pkg::ST_IDLE;
				end else if (sts.cur_present) begin
					cmd.rd_hi = 1'b1;
					state_d   = isfd_pkg::ST_RDLO;
				end else begin
					cmd.skip = 1'b1;
				end
			end
			isfd_pkg::ST_RDLO: begin
				cmd.rd_lo = 1'b1;
				state_d   = isfd_pkg::ST_WORD;
			end
			isfd_pkg::ST_WORD: begin
				cmd.cap_word = 1'b1;
				state_d      = isfd_pkg::ST_MUL;
			end
			isfd_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = isfd_pkg::ST_EMIT;
			end
			isfd_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = isfd_pkg::ST_SCAN;
				end
			end
			default: begin
				state_d = isfd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/isfd_dp.sv
// frame buffer, position tracking, word assembly, temperature scaling, result register
module isfd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [7:0]                          rx_byte,
	input  isfd_pkg::cmd_t                      cmd,
	output isfd_pkg::sts_t                      sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [isfd_pkg::QTY_W-1:0]          quantity,
	output logic signed [isfd_pkg::VAL_W-1:0]   value,
	output logic                                last
);

	localparam int AW = isfd_pkg::ADDR_W;
	localparam int OW = isfd_pkg::OFF_W;
	localparam int TW = isfd_pkg::TGT_W;

	logic [AW-1:0]                   pos_q;
	logic [7:0]                      mask_q;
	logic [7:0]                      len_q;
	logic [isfd_pkg::BUF_DEPTH-1:0]  vld_q;
	logic [isfd_pkg::QTY_W-1:0]      qidx_q;
	logic [OW-1:0]                   off_q;
	logic [7:0]                      hi_q;
	logic [isfd_pkg::VAL_W-1:0]      word_q;
	logic [isfd_pkg::PROD_W-1:0]     prod_q;
	logic                            rd_ok_s1;
	logic                            out_valid_q;
	logic [isfd_pkg::QTY_W-1:0]      quantity_q;
	logic [isfd_pkg::VAL_W-1:0]      value_q;
	logic                            last_q;

	logic [AW:0]                     count;
	logic [7:0]                      len_sel;
	logic [TW-1:0]                   target;
	logic                            is_hdr;
	logic                            frame_done;
	logic [AW-1:0]                   pos_d;
	logic [isfd_pkg::N_QTY-1:0]      pres;
	logic [isfd_pkg::N_QTY-1:0]      above;
	logic                            rd_en;
	logic [OW-1:0]                   rd_off;
	logic                            rd_in_range;
	logic [7:0]                      rdata;
	logic [7:0]                      rbyte;
	logic [isfd_pkg::VAL_W-1:0]      temp_val;

	// byte intake: header check, length check and frame end
	always_comb begin
		count      = {1'b0, pos_q} + (AW+1)'(1);
		is_hdr     = (rx_byte == isfd_pkg::HDR_BYTE);
		len_sel    = (pos_q == AW'(3)) ? rx_byte : len_q;
		target     = {1'b0, len_sel} + isfd_pkg::LEN_EXTRA;
		frame_done = 1'b0;
		pos_d      = count[AW-1:0];
		if ((pos_q == '0 || pos_q == AW'(1)) && !is_hdr) begin
			pos_d = '0;
		end else if (count >= (AW+1)'(4)) begin
			if (target > TW'(isfd_pkg::BUF_DEPTH)) begin
				pos_d = '0;
			end else if (TW'(count) == target) begin
				pos_d      = '0;
				frame_done = 1'b1;
			end else if (count >= (AW+1)'(isfd_pkg::BUF_DEPTH)) begin
				pos_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vld_q <= '0;
		end else if (cmd.wr) begin
			pos_q        <= pos_d;
			vld_q[pos_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && pos_q == AW'(2)) begin
			mask_q <= rx_byte;
		end
		if (cmd.wr && pos_q == AW'(3)) begin
			len_q <= rx_byte;
		end
	end

	// buffer reads during decode; never-written or out-of-buffer bytes read as zero
	assign rd_en       = cmd.rd_hi || cmd.rd_lo;
	assign rd_off      = cmd.rd_lo ? off_q + OW'(1) : off_q;
	assign rd_in_range = ({1'b0, rd_off} < (OW+1)'(isfd_pkg::BUF_DEPTH));

	isfd_ram #(
		.WIDTH(8),
		.DEPTH(isfd_pkg::BUF_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(pos_q),
		.wdata(rx_byte),
		.re   (rd_en),
		.raddr(rd_off[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ok_s1 <= rd_in_range && vld_q[rd_off[AW-1:0]];
		end
	end

	assign rbyte = rd_ok_s1 ? rdata : 8'h00;

	// quantity scan
	assign pres  = isfd_pkg::present_vec(mask_q);
	assign above = pres >> qidx_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qidx_q <= '0;
			off_q  <= isfd_pkg::FIRST_OFF;
		end else if (cmd.skip) begin
			qidx_q <= qidx_q + isfd_pkg::QTY_W'(1);
		end else if (cmd.emit) begin
			qidx_q <= qidx_q + isfd_pkg::QTY_W'(1);
			off_q  <= off_q + OW'(2);
		end
		if (cmd.rd_lo) begin
			hi_q <= rbyte;
		end
		if (cmd.cap_word) begin
			word_q <= {hi_q, rbyte};
		end
		if (cmd.mul) begin
			prod_q <= isfd_pkg::PROD_W'(word_q * isfd_pkg::TEMP_RECIP);
		end
	end

	assign temp_val = isfd_pkg::VAL_W'(prod_q[isfd_pkg::PROD_W-1:isfd_pkg::TEMP_SHIFT]);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			quantity_q <= qidx_q;
			value_q    <= (qidx_q == isfd_pkg::QTY_TEMP) ? temp_val : word_q;
			last_q     <= (above[isfd_pkg::N_QTY-1:1] == '0);
		end
	end

	assign sts.frame_done  = frame_done;
	assign sts.cur_present = above[0];
	assign sts.scan_end    = (qidx_q == isfd_pkg::QTY_W'(isfd_pkg::N_QTY));
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign quantity  = quantity_q;
	assign value     = value_q;
	assign last      = last_q;

endmodule

>>> rtl/imu_serial_frame_decoder.sv
// top level of the imu serial frame decoder
//
//   channel  dir  payload                      beat
//   rx       in   rx_byte[7:0]                 one received serial byte
//   res      out  quantity[3:0] value[15:0]    one decoded quantity, last on final one
//                 last
//
// a byte that does not end a frame is taken and rx.ready stays high
// a frame end starts a decode pass with rx.ready low: a skip per unselected quantity
// slot, and per selected one two buffer reads, word capture, scaling multiply and
// issue, then a closing step; the single read port needs the two separate reads
// res stalls only hold the issue step; rx is taken again once the pass ends
// arst_n clears the position, the buffer valid bits and the result valid flag
module imu_serial_frame_decoder (
	input  logic       clk,
	input  logic       arst_n,
	isfd_in_if.sink    rx,
	isfd_out_if.source res
);

	isfd_pkg::cmd_t cmd;
	isfd_pkg::sts_t sts;

	isfd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rx.valid),
		.in_ready(rx.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	isfd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx.rx_byte),
		.cmd      (cmd),
		.sts      (sts),
		.out_ready(res.ready),
		.out_valid(res.valid),
		.quantity (res.quantity),
		.value    (res.value),
		.last     (res.last)
	);

	// a result is only loaded when the result register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result issued over a pending result");

	// buffer writes and decode reads never share a cycle
	a_no_rw_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> !(cmd.rd_hi || cmd.rd_lo))
		else $error("buffer write during decode read");

	// a completed frame stalls intake for its decode pass
	a_stall_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !rx.ready)
		else $error("intake open right after frame end");

endmodule

>>> bench/imu_serial_frame_decoder_tb.sv
// self-checking testbench for the imu serial frame decoder: directed table, then random frames
module imu_serial_frame_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [isfd_pkg::QTY_W-1:0] QTY_ACC_X = 4'd0;
	localparam logic [isfd_pkg::QTY_W-1:0] QTY_GYR_X = 4'd3;
	localparam logic [isfd_pkg::QTY_W-1:0] QTY_ANG_X = 4'd6;
	localparam int RANDOM_BYTES = 480;
	localparam int MAX_GAP      = 18;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [isfd_pkg::QTY_W-1:0]        qty;
		logic signed [isfd_pkg::VAL_W-1:0] val;
		logic                              last;
	} reading_t;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct {
		logic [7:0]                 b;
		bit                         typed;
		bit                         has_res;
		logic [isfd_pkg::QTY_W-1:0] qty;
		logic [isfd_pkg::VAL_W-1:0] val;
	} row_t;

	logic clk;
	logic arst_n;

	isfd_in_if  rx();
	isfd_out_if res();

	imu_serial_frame_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res)
	);

	// decoder shadow state
	int         frame_pos;
	logic [7:0] frame_buf [isfd_pkg::BUF_DEPTH];
	reading_t   decoded[$];
	reading_t   pending_readings[$];
	row_t       directed_rows[$];

	int errors;
	int idle_cycles;
	bit calm_src;
	bit calm_sink;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] buf_word(int idx);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = (idx < isfd_pkg::BUF_DEPTH) ? frame_buf[idx] : 8'h00;
		lo = (idx + 1 < isfd_pkg::BUF_DEPTH) ? frame_buf[idx + 1] : 8'h00;
		return {hi, lo};
	endfunction

	function automatic void add_reading(logic [isfd_pkg::QTY_W-1:0] q, logic [15:0] v);
		reading_t r;
		r.qty  = q;
		r.val  = v;
		r.last = 1'b0;
		decoded.push_back(r);
	endfunction

	function automatic void decode_frame();
		logic [7:0] mask;
		int off;
		int k;
		mask = frame_buf[2];
		off  = 4;
		if ((mask & isfd_pkg::MASK_ACC) != 0)
			for (k = 0; k < 3; k++) begin
				add_reading(QTY_ACC_X + 4'(k), buf_word(off));
				off += 2;
			end
		if ((mask & isfd_pkg::MASK_GYR) != 0)
			for (k = 0; k < 3; k++) begin
				add_reading(QTY_GYR_X + 4'(k), buf_word(off));
				off += 2;
			end
		if ((mask & isfd_pkg::MASK_ANG) != 0)
			for (k = 0; k < 3; k++) begin
				add_reading(QTY_ANG_X + 4'(k), buf_word(off));
				off += 2;
			end
		if ((mask & isfd_pkg::MASK_TMP) != 0)
			add_reading(isfd_pkg::QTY_TEMP, buf_word(off) / 16'd100);
		if (decoded.size() > 0)
			decoded[decoded.size() - 1].last = 1'b1;
	endfunction

	// advance the shadow state by one byte, results land in decoded
	function automatic void absorb_byte(logic [7:0] b);
		int pos;
		int cnt;
		int tgt;
		decoded.delete();
		pos = frame_pos;
		if (pos >= isfd_pkg::BUF_DEPTH)
			pos = 0;
		frame_buf[pos] = b;
		cnt = pos + 1;
		if ((pos == 0 || pos == 1) && b != isfd_pkg::HDR_BYTE) begin
			frame_pos = 0;
			return;
		end
		if (cnt >= 4) begin
			tgt = int'(frame_buf[3]) + int'(isfd_pkg::LEN_EXTRA);
			if (tgt > isfd_pkg::BUF_DEPTH) begin
				frame_pos = 0;
				return;
			end
			if (cnt == tgt) begin
				frame_pos = 0;
				decode_frame();
				return;
			end
		end
		if (cnt >= isfd_pkg::BUF_DEPTH)
			cnt = 0;
		frame_pos = cnt;
	endfunction

	function automatic void add_row(logic [7:0] b, bit typed, bit has_res,
			logic [isfd_pkg::QTY_W-1:0] q, logic [isfd_pkg::VAL_W-1:0] v);
		row_t r;
		r.b       = b;
		r.typed   = typed;
		r.has_res = has_res;
		r.qty     = q;
		r.val     = v;
		directed_rows.push_back(r);
	endfunction

	// present one byte after a random gap, wait for the beat, then update the shadow
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = calm_src ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (rx.ready !== 1'b1);
		absorb_byte(b);
		if ($urandom_range(0, 30) == 0)
			calm_src = !calm_src;
	endtask

	task automatic feed(input logic [7:0] b, inout int count);
		send_byte(b);
		foreach (decoded[i])
			pending_readings.push_back(decoded[i]);
		count++;
	endtask

	// result ready with random stalls
	initial begin : sink_drive
		int gap;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = calm_sink ? 0 : $urandom_range(0, MAX_GAP);
			@(negedge clk);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (res.valid !== 1'b1);
			if ($urandom_range(0, 30) == 0)
				calm_sink = !calm_sink;
		end
	end

	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected result: quantity %0d value %0d last %0b",
					res.quantity, $signed(res.value), res.last);
				errors++;
			end else begin
				want = pending_readings.pop_front();
				if (res.quantity !== want.qty) begin
					$error("quantity: expected %0d, got %0d", want.qty, res.quantity);
					errors++;
				end
				if (res.value !== want.val) begin
					$error("value: expected %0d, got %0d", $signed(want.val),
						$signed(res.value));
					errors++;
				end
				if (res.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, res.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((rx.valid === 1'b1 && rx.ready === 1'b1) ||
				(res.valid === 1'b1 && res.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		reading_t r;
		row_t row;
		int sent;
		int choice;
		int words;
		int len;
		int k;
		bit paused;
		logic [7:0] mask;
		logic [7:0] b;
		arst_n     = 1'b0;
		rx.valid   = 1'b0;
		rx.rx_byte = 8'h00;
		errors      = 0;
		idle_cycles = 0;
		calm_src    = 1'b0;
		calm_sink   = 1'b0;
		frame_pos   = 0;
		foreach (frame_buf[i])
			frame_buf[i] = 8'h00;
		sent   = 0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// bad first header byte
		add_row(8'h00, 1, 0, '0, '0);
		// bad second header byte, not taken as a new first byte
		add_row(isfd_pkg::HDR_BYTE, 1, 0, '0, '0);
		add_row(8'hff, 1, 0, '0, '0);
		// temperature only, largest word
		add_row(isfd_pkg::HDR_BYTE, 1, 0, '0, '0);
		add_row(isfd_pkg::HDR_BYTE, 1, 0, '0, '0);
		add_row(isfd_pkg::MASK_TMP, 1, 0, '0, '0);
		add_row(8'h02, 1, 0, '0, '0);
		add_row(8'hff, 1, 0, '0, '0);
		add_row(8'hff, 1, 0, '0, '0);
		add_row(8'h00, 1, 1, isfd_pkg::QTY_TEMP, 16'd655);
		// length too big for the buffer, dropped on the length byte
		add_row(isfd_pkg::HDR_BYTE, 1, 0, '0, '0);
		add_row(isfd_pkg::HDR_BYTE, 1, 0, '0, '0);
		add_row(8'h13, 1, 0, '0, '0);
		add_row(8'h1c, 1, 0, '0, '0);
		// empty mask, complete frame with no result
		add_row(isfd_pkg::HDR_BYTE, 1, 0, '0, '0);
		add_row(isfd_pkg::HDR_BYTE, 1, 0, '0, '0);
		add_row(8'h00, 1, 0, '0, '0);
		add_row(8'h00, 1, 0, '0, '0);
		add_row(8'h3c, 1, 0, '0, '0);
		// every bit of the mask, zero length: words come from leftover bytes
		add_row(isfd_pkg::HDR_BYTE, 1, 0, '0, '0);
		add_row(isfd_pkg::HDR_BYTE, 1, 0, '0, '0);
		add_row(8'hff, 1, 0, '0, '0);
		add_row(8'h00, 1, 0, '0, '0);
		add_row(8'hab, 0, 0, '0, '0);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_byte(row.b);
			if (row.typed) begin
				if (row.has_res) begin
					r.qty  = row.qty;
					r.val  = row.val;
					r.last = 1'b1;
					pending_readings.push_back(r);
				end
			end else begin
				foreach (decoded[j])
					pending_readings.push_back(decoded[j]);
			end
		end

		while (sent < RANDOM_BYTES) begin
			if (!paused && sent >= RANDOM_BYTES / 2) begin
				// hold the sender until every decoded result has drained
				paused = 1'b1;
				@(negedge clk);
				rx.valid <= 1'b0;
				while (pending_readings.size() != 0) @(posedge clk);
			end
			choice = $urandom_range(0, 99);
			if (choice < 12) begin
				// line noise, mostly ignored at position zero
				feed(8'($urandom_range(0, 255)), sent);
			end else if (choice < 17) begin
				feed(isfd_pkg::HDR_BYTE, sent);
				b = 8'($urandom_range(0, 255));
				if (b == isfd_pkg::HDR_BYTE)
					b = 8'h5b;
				feed(b, sent);
			end else if (choice < 22) begin
				feed(isfd_pkg::HDR_BYTE, sent);
				feed(isfd_pkg::HDR_BYTE, sent);
				feed(8'($urandom_range(0, 255)), sent);
				feed(8'($urandom_range(isfd_pkg::BUF_DEPTH - 4, 255)), sent);
			end else begin
				mask = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 1) == 1)
					mask = mask & (isfd_pkg::MASK_ACC | isfd_pkg::MASK_GYR |
						isfd_pkg::MASK_ANG | isfd_pkg::MASK_TMP);
				words = 0;
				if ((mask & isfd_pkg::MASK_ACC) != 0) words += 3;
				if ((mask & isfd_pkg::MASK_GYR) != 0) words += 3;
				if ((mask & isfd_pkg::MASK_ANG) != 0) words += 3;
				if ((mask & isfd_pkg::MASK_TMP) != 0) words += 1;
				if ($urandom_range(0, 9) < 6)
					len = 2 * words + $urandom_range(0, 3);
				else
					len = $urandom_range(0, isfd_pkg::BUF_DEPTH - 5);
				if (len > isfd_pkg::BUF_DEPTH - 5)
					len = isfd_pkg::BUF_DEPTH - 5;
				feed(isfd_pkg::HDR_BYTE, sent);
				feed(isfd_pkg::HDR_BYTE, sent);
				feed(mask, sent);
				feed(8'(len), sent);
				for (k = 0; k < len; k++) begin
					case ($urandom_range(0, 9))
						0: b = 8'h00;
						1: b = 8'hff;
						2: b = 8'h80;
						3: b = 8'h7f;
						default: b = 8'($urandom_range(0, 255));
					endcase
					feed(b, sent);
				end
				// checksum, never checked
				feed(8'($urandom_range(0, 255)), sent);
			end
		end

		@(negedge clk);
		rx.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> imu_serial_frame_decoder.f
rtl/isfd_pkg.sv
rtl/isfd_if.sv
rtl/isfd_ram.sv
rtl/isfd_ctrl.sv
rtl/isfd_dp.sv
rtl/imu_serial_frame_decoder.sv
bench/imu_serial_frame_decoder_tb.sv
